### rtl/core/linear_blend_skinning_2d_core_defines.svh
// Assertion macros for the skinning core checker.
`ifndef LINEAR_BLEND_SKINNING_2D_CORE_DEFINES_SVH
`define LINEAR_BLEND_SKINNING_2D_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBS2D_ASSERT_NOW(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("lbs2d: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBS2D_ASSERT_NEXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
    else $error("lbs2d: next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define LBS2D_ASSERT_ALWAYS(lbl, ck, a, c) \
  lbl: assert property (@(posedge ck) (a) |=> (c)) \
    else $error("lbs2d: reset check failed");

`endif

### rtl/core/lbs2d_pkg.sv
// Shared types and widths for the 2-D skinning core.
`timescale 1ns / 1ps
package lbs2d_pkg;

  localparam int CoordW = 16;
  localparam int TermXyW = 22;
  localparam int TermZW = 18;

  // One weighted binding delta, ready to accumulate.
  typedef struct packed {
    logic signed [TermXyW-1:0] term_x;
    logic signed [TermXyW-1:0] term_y;
    logic signed [TermZW-1:0]  term_z;
    logic signed [CoordW-1:0]  pose_x;
    logic signed [CoordW-1:0]  pose_y;
    logic signed [CoordW-1:0]  pose_z;
    logic                      last;
  } lbs2d_entry_t;

endpackage

### rtl/core/linear_blend_skinning_2d_core.sv
// Top level of the 2-D linear blend skinning core.
`timescale 1ns / 1ps
// Takes one point-to-pivot binding per cycle while in_ready is high and
// returns one skinned point (X, Y, Z in Q12.4, saturated) for each binding
// flagged as the point's last. The front end is a 5-stage multiply pipe that
// turns each binding into rounded weighted deltas; a queue of QUEUE_DEPTH
// entries decouples it from the back end, whose saturating accumulator add
// sets the sustained rate of one binding per clock while the final stage can
// take each last binding. A binding passes the 5 pipe stages and a queue
// slot; a last one is accumulated into the final-sum register and its result
// then goes to the output register. Reset clears the accumulators; send a
// point with no pivots as one binding of weight 0.
module linear_blend_skinning_2d_core import lbs2d_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_point_x,
  input  logic signed [15:0] in_point_y,
  input  logic signed [15:0] in_point_z,
  input  logic signed [15:0] in_pivot_x,
  input  logic signed [15:0] in_pivot_y,
  input  logic signed [15:0] in_cos_angle,
  input  logic signed [15:0] in_sin_angle,
  input  logic signed [15:0] in_move_x,
  input  logic signed [15:0] in_move_y,
  input  logic signed [15:0] in_move_z,
  input  logic [15:0]        in_weight,
  input  logic               in_last_binding,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z
);

  logic         push_valid, push_ready, pop_valid, pop_ready;
  lbs2d_entry_t push_data, pop_data;

  lbs2d_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_z      (in_point_z),
    .in_pivot_x      (in_pivot_x),
    .in_pivot_y      (in_pivot_y),
    .in_cos_angle    (in_cos_angle),
    .in_sin_angle    (in_sin_angle),
    .in_move_x       (in_move_x),
    .in_move_y       (in_move_y),
    .in_move_z       (in_move_z),
    .in_weight       (in_weight),
    .in_last_binding (in_last_binding),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  lbs2d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  lbs2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

endmodule

### rtl/core/lbs2d_front.sv
// Front end: accepts bindings and forms the rounded weighted deltas in a 5-stage pipe.
`timescale 1ns / 1ps
module lbs2d_front import lbs2d_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       in_point_x,
  input  logic signed [15:0]       in_point_y,
  input  logic signed [15:0]       in_point_z,
  input  logic signed [15:0]       in_pivot_x,
  input  logic signed [15:0]       in_pivot_y,
  input  logic signed [15:0]       in_cos_angle,
  input  logic signed [15:0]       in_sin_angle,
  input  logic signed [15:0]       in_move_x,
  input  logic signed [15:0]       in_move_y,
  input  logic signed [15:0]       in_move_z,
  input  logic [15:0]              in_weight,
  input  logic                     in_last_binding,
  output logic                     push_valid,
  input  logic                     push_ready,
  output lbs2d_entry_t             push_data
);

  logic en;
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;

  // Payload carried along the stages (the weight only as far as stage 3).
  logic signed [15:0] s1_px_r, s1_py_r, s1_pz_r, s2_px_r, s2_py_r, s2_pz_r;
  logic signed [15:0] s3_px_r, s3_py_r, s3_pz_r, s4_px_r, s4_py_r, s4_pz_r;
  logic signed [15:0] s5_px_r, s5_py_r, s5_pz_r;
  logic s1_last_r, s2_last_r, s3_last_r, s4_last_r, s5_last_r;
  logic [15:0] s1_w_r, s2_w_r, s3_w_r;

  // Stage 1: offsets
  logic signed [16:0] dx_nxt, dy_nxt, s1_dx_r, s1_dy_r;
  logic signed [15:0] s1_c_r, s1_s_r, s1_mx_r, s1_my_r, s1_mz_r;

  // Stage 2: products
  logic signed [32:0] pxc_nxt, pys_nxt, pxs_nxt, pyc_nxt, mzw_nxt;
  logic signed [32:0] s2_pxc_r, s2_pys_r, s2_pxs_r, s2_pyc_r, s2_mzw_r;
  logic signed [17:0] mdx_nxt, mdy_nxt, s2_mdx_r, s2_mdy_r;
  logic signed [17:0] w_s18_s1;

  // Stage 3: unweighted deltas, Z term
  logic signed [34:0] ex_nxt, ey_nxt, s3_ex_r, s3_ey_r;
  logic signed [32:0] z_rnd;
  logic signed [TermZW-1:0] tz_nxt, s3_tz_r, s4_tz_r, s5_tz_r;

  // Stage 4: partial products of delta times weight
  logic [33:0] lox_nxt, loy_nxt, s4_lox_r, s4_loy_r;
  logic signed [33:0] hix_nxt, hiy_nxt, s4_hix_r, s4_hiy_r;
  logic signed [16:0] w_s17_s3;

  // Stage 5: recombine and round
  logic signed [50:0] fx, fy;
  logic signed [TermXyW-1:0] tx_nxt, ty_nxt, s5_tx_r, s5_ty_r;

  assign en = !s5_v_r || push_ready;
  assign in_ready = en;

  assign dx_nxt = 17'(in_point_x) - 17'(in_pivot_x);
  assign dy_nxt = 17'(in_point_y) - 17'(in_pivot_y);

  assign w_s18_s1 = signed'({2'b00, s1_w_r});
  assign pxc_nxt = 33'(s1_dx_r) * 33'(s1_c_r);
  assign pys_nxt = 33'(s1_dy_r) * 33'(s1_s_r);
  assign pxs_nxt = 33'(s1_dx_r) * 33'(s1_s_r);
  assign pyc_nxt = 33'(s1_dy_r) * 33'(s1_c_r);
  assign mzw_nxt = 33'(s1_mz_r) * 33'(w_s18_s1);
  assign mdx_nxt = 18'(s1_mx_r) - 18'(s1_dx_r);
  assign mdy_nxt = 18'(s1_my_r) - 18'(s1_dy_r);

  assign ex_nxt = 35'(s2_pxc_r) - 35'(s2_pys_r) + (35'(s2_mdx_r) <<< 14);
  assign ey_nxt = 35'(s2_pxs_r) + 35'(s2_pyc_r) + (35'(s2_mdy_r) <<< 14);
  assign z_rnd  = s2_mzw_r + 33'sd16384;
  assign tz_nxt = TermZW'(z_rnd >>> 15);

  assign w_s17_s3 = signed'({1'b0, s3_w_r});
  assign lox_nxt = 34'(s3_ex_r[17:0]) * 34'(s3_w_r);
  assign loy_nxt = 34'(s3_ey_r[17:0]) * 34'(s3_w_r);
  assign hix_nxt = 34'(signed'(s3_ex_r[34:18])) * 34'(w_s17_s3);
  assign hiy_nxt = 34'(signed'(s3_ey_r[34:18])) * 34'(w_s17_s3);

  // Round half up: add half an LSB of the Q.4 result, then shift.
  assign fx = (51'(s4_hix_r) <<< 18) + 51'(signed'({1'b0, s4_lox_r})) + 51'sd268435456;
  assign fy = (51'(s4_hiy_r) <<< 18) + 51'(signed'({1'b0, s4_loy_r})) + 51'sd268435456;
  assign tx_nxt = TermXyW'(fx >>> 29);
  assign ty_nxt = TermXyW'(fy >>> 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r   <= dx_nxt;
      s1_dy_r   <= dy_nxt;
      s1_c_r    <= in_cos_angle;
      s1_s_r    <= in_sin_angle;
      s1_mx_r   <= in_move_x;
      s1_my_r   <= in_move_y;
      s1_mz_r   <= in_move_z;
      s1_w_r    <= in_weight;
      s1_px_r   <= in_point_x;
      s1_py_r   <= in_point_y;
      s1_pz_r   <= in_point_z;
      s1_last_r <= in_last_binding;

      s2_pxc_r  <= pxc_nxt;
      s2_pys_r  <= pys_nxt;
      s2_pxs_r  <= pxs_nxt;
      s2_pyc_r  <= pyc_nxt;
      s2_mzw_r  <= mzw_nxt;
      s2_mdx_r  <= mdx_nxt;
      s2_mdy_r  <= mdy_nxt;
      s2_w_r    <= s1_w_r;
      s2_px_r   <= s1_px_r;
      s2_py_r   <= s1_py_r;
      s2_pz_r   <= s1_pz_r;
      s2_last_r <= s1_last_r;

      s3_ex_r   <= ex_nxt;
      s3_ey_r   <= ey_nxt;
      s3_tz_r   <= tz_nxt;
      s3_w_r    <= s2_w_r;
      s3_px_r   <= s2_px_r;
      s3_py_r   <= s2_py_r;
      s3_pz_r   <= s2_pz_r;
      s3_last_r <= s2_last_r;

      s4_lox_r  <= lox_nxt;
      s4_loy_r  <= loy_nxt;
      s4_hix_r  <= hix_nxt;
      s4_hiy_r  <= hiy_nxt;
      s4_tz_r   <= s3_tz_r;
      s4_px_r   <= s3_px_r;
      s4_py_r   <= s3_py_r;
      s4_pz_r   <= s3_pz_r;
      s4_last_r <= s3_last_r;

      s5_tx_r   <= tx_nxt;
      s5_ty_r   <= ty_nxt;
      s5_tz_r   <= s4_tz_r;
      s5_px_r   <= s4_px_r;
      s5_py_r   <= s4_py_r;
      s5_pz_r   <= s4_pz_r;
      s5_last_r <= s4_last_r;
    end
  end

  assign push_valid = s5_v_r;

  always_comb begin
    push_data.term_x = s5_tx_r;
    push_data.term_y = s5_ty_r;
    push_data.term_z = s5_tz_r;
    push_data.pose_x = s5_px_r;
    push_data.pose_y = s5_py_r;
    push_data.pose_z = s5_pz_r;
    push_data.last   = s5_last_r;
  end

endmodule

### rtl/core/lbs2d_fifo.sv
// Short register queue between the front and back ends.
`timescale 1ns / 1ps
module lbs2d_fifo import lbs2d_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  lbs2d_entry_t push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output lbs2d_entry_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  lbs2d_entry_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign push_ready = (count_r != CntW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/lbs2d_back.sv
// Back end: saturating accumulators, final sum stage and output register.
`timescale 1ns / 1ps
module lbs2d_back import lbs2d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  lbs2d_entry_t         pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_x,
  output logic signed [15:0]   out_y,
  output logic signed [15:0]   out_z
);

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if (v > 33'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -33'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic signed [31:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [31:0] acc_x, acc_y, acc_z;
  logic signed [31:0] fin_x_r, fin_y_r, fin_z_r;
  logic signed [15:0] fin_px_r, fin_py_r, fin_pz_r;
  logic fin_valid_r, fin_go, do_pop;
  logic out_valid_r;
  logic signed [15:0] out_x_r, out_y_r, out_z_r;

  assign acc_x = sat32(33'(sum_x_r) + 33'(pop_data.term_x));
  assign acc_y = sat32(33'(sum_y_r) + 33'(pop_data.term_y));
  assign acc_z = sat32(33'(sum_z_r) + 33'(pop_data.term_z));

  assign fin_go    = fin_valid_r && (!out_valid_r || out_ready);
  // Hold a last binding while the final stage is still occupied.
  assign pop_ready = !pop_data.last || !fin_valid_r || fin_go;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      fin_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_pop) begin
        if (pop_data.last) begin
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
        end else begin
          sum_x_r <= acc_x;
          sum_y_r <= acc_y;
          sum_z_r <= acc_z;
        end
      end
      if (do_pop && pop_data.last) begin
        fin_valid_r <= 1'b1;
      end else if (fin_go) begin
        fin_valid_r <= 1'b0;
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_data.last) begin
      fin_x_r  <= acc_x;
      fin_y_r  <= acc_y;
      fin_z_r  <= acc_z;
      fin_px_r <= pop_data.pose_x;
      fin_py_r <= pop_data.pose_y;
      fin_pz_r <= pop_data.pose_z;
    end
    if (fin_go) begin
      out_x_r <= sat16(33'(fin_px_r) + 33'(fin_x_r));
      out_y_r <= sat16(33'(fin_py_r) + 33'(fin_y_r));
      out_z_r <= sat16(33'(fin_pz_r) + 33'(fin_z_r));
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

### rtl/core/lbs2d_checker.sv
// Port-level checks for the skinning core, bound to the top level.
`timescale 1ns / 1ps
`include "linear_blend_skinning_2d_core_defines.svh"
module lbs2d_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_last_binding,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z
);

  // Points whose last binding went in but whose result has not come out.
  logic [4:0] pend_r;
  logic in_last_acc, out_acc;

  assign in_last_acc = in_valid && in_ready && in_last_binding;
  assign out_acc     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_last_acc && !(out_acc && pend_r != '0)) begin
      pend_r <= pend_r + 1'b1;
    end else if (!in_last_acc && out_acc && pend_r != '0) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  `LBS2D_ASSERT_NOW(a_result_has_point, clk, rst_n, out_valid, pend_r != 5'd0)
  `LBS2D_ASSERT_ALWAYS(a_reset_drops_result, clk, !rst_n, !out_valid)
  `LBS2D_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z))

endmodule

bind linear_blend_skinning_2d_core lbs2d_checker u_lbs2d_checker (.*);
